### sv/gsc_pkg.sv
`timescale 1ns / 1ps
package gsc_pkg;
  localparam int BUTTON_COUNT_DEFAULT = 15;
  localparam int BUTTON_WIDTH = 15;
  localparam int CFG_INDEX_WIDTH = 2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_DEAD_ZONE = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_INVERT_PITCH = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_TRIGGER_THRESHOLD = 2'd2;
  localparam logic [14:0] DEAD_ZONE_RESET = 15'd4915;
  localparam logic [14:0] TRIGGER_THRESHOLD_RESET = 15'd6554;

  typedef enum logic [2:0] {
    LN_IDLE, LN_ZONE, LN_SQRT, LN_SCALE, LN_DIV, LN_MUL, LN_AXIS, LN_DONE
  } lane_state_t;

  typedef struct packed {
    logic start;
    logic [14:0] dead_zone;
  } lane_ctrl_t;
endpackage

### sv/gsc_lane.sv
`timescale 1ns / 1ps
module gsc_lane (
  input  logic                clk,
  input  logic                rst,
  input  gsc_pkg::lane_ctrl_t ctrl,
  input  logic signed [15:0]  raw_x,
  input  logic signed [15:0]  raw_y,
  output logic                done,
  output logic signed [17:0]  out_x,
  output logic signed [17:0]  out_y
);
  import gsc_pkg::*;

  lane_state_t state, state_next;
  logic signed [17:0] x, y;
  logic [14:0] dz;
  logic [47:0] rad;
  logic [25:0] rem;
  logic [23:0] root;
  logic [4:0] cnt;
  logic [23:0] drem;
  logic [23:0] sc;
  logic [23:0] xrem, yrem;
  logic [16:0] xnum, ynum, xq, yq;
  logic [17:0] nx, ny;
  logic [16:0] ax, ay;
  logic [31:0] s2c;
  logic [29:0] dz2;
  logic [27:0] r2, rtrial;
  logic [25:0] rem_next;
  logic [23:0] root_next;
  logic [23:0] d, den, diff;
  logic [24:0] dsh;
  logic dbit;
  logic [23:0] drem_next;
  logic [39:0] xprod, yprod;
  logic [24:0] xs, ys;
  logic xge, yge;
  logic [23:0] xrem_next, yrem_next;
  logic [16:0] xq_next, yq_next;

  always_comb begin
    nx = {{2{raw_x[15]}}, raw_x} + ((!raw_x[15] && raw_x[14]) ? 18'd1 : 18'd0);
    ny = {{2{raw_y[15]}}, raw_y} + ((!raw_y[15] && raw_y[14]) ? 18'd1 : 18'd0);
    ax = x[17] ? 17'(-x) : 17'(x);
    ay = y[17] ? 17'(-y) : 17'(y);
    s2c = ({15'd0, ax} * {15'd0, ax}) + ({15'd0, ay} * {15'd0, ay});
    dz2 = {15'd0, dz} * {15'd0, dz};
    // square root, one result bit per step
    r2 = {rem, rad[47:46]};
    rtrial = {2'd0, root, 2'b01};
    if (r2 >= rtrial) begin
      rem_next = 26'(r2 - rtrial);
      root_next = {root[22:0], 1'b1};
    end else begin
      rem_next = r2[25:0];
      root_next = {root[22:0], 1'b0};
    end
    // scale divider
    d = {1'b0, dz, 8'd0};
    den = 24'h800000 - d;
    diff = root - d;
    dsh = {drem, 1'b0};
    dbit = (dsh >= {1'b0, den});
    drem_next = dbit ? 24'(dsh - {1'b0, den}) : dsh[23:0];
    // axis products and dividers
    xprod = ({23'd0, ax} * {16'd0, sc}) + {17'd0, root[23:1]};
    yprod = ({23'd0, ay} * {16'd0, sc}) + {17'd0, root[23:1]};
    xs = {xrem, xnum[16]};
    ys = {yrem, ynum[16]};
    xge = (xs >= {1'b0, root});
    yge = (ys >= {1'b0, root});
    xrem_next = xge ? 24'(xs - {1'b0, root}) : xs[23:0];
    yrem_next = yge ? 24'(ys - {1'b0, root}) : ys[23:0];
    xq_next = {xq[15:0], xge};
    yq_next = {yq[15:0], yge};
  end

  always_comb begin
    state_next = state;
    case (state)
      LN_IDLE: if (ctrl.start) state_next = LN_ZONE;
      LN_ZONE: state_next = (s2c <= {2'd0, dz2}) ? LN_DONE : LN_SQRT;
      LN_SQRT: if (cnt == 5'd0) state_next = LN_SCALE;
      LN_SCALE: state_next = (diff >= den) ? LN_MUL : LN_DIV;
      LN_DIV: if (cnt == 5'd0) state_next = LN_MUL;
      LN_MUL: state_next = LN_AXIS;
      LN_AXIS: if (cnt == 5'd0) state_next = LN_DONE;
      LN_DONE: state_next = LN_IDLE;
      default: state_next = LN_IDLE;
    endcase
  end

  always_comb begin
    done = (state == LN_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= LN_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      LN_IDLE: begin
        if (ctrl.start) begin
          x <= nx;
          y <= ny;
          dz <= ctrl.dead_zone;
        end
      end
      LN_ZONE: begin
        if (s2c <= {2'd0, dz2}) begin
          x <= 18'sd0;
          y <= 18'sd0;
        end
        rad <= {s2c, 16'd0};
        rem <= 26'd0;
        root <= 24'd0;
        cnt <= 5'd23;
      end
      LN_SQRT: begin
        rad <= {rad[45:0], 2'b00};
        rem <= rem_next;
        root <= root_next;
        cnt <= cnt - 5'd1;
      end
      LN_SCALE: begin
        if (diff >= den) begin
          sc <= 24'h800000;
        end else begin
          drem <= diff;
          sc <= 24'd0;
          cnt <= 5'd22;
        end
      end
      LN_DIV: begin
        drem <= drem_next;
        sc <= {sc[22:0], dbit};
        cnt <= cnt - 5'd1;
      end
      LN_MUL: begin
        xrem <= {1'b0, xprod[39:17]};
        yrem <= {1'b0, yprod[39:17]};
        xnum <= xprod[16:0];
        ynum <= yprod[16:0];
        xq <= 17'd0;
        yq <= 17'd0;
        cnt <= 5'd16;
      end
      LN_AXIS: begin
        xrem <= xrem_next;
        yrem <= yrem_next;
        xnum <= {xnum[15:0], 1'b0};
        ynum <= {ynum[15:0], 1'b0};
        xq <= xq_next;
        yq <= yq_next;
        cnt <= cnt - 5'd1;
        if (cnt == 5'd0) begin
          x <= x[17] ? -{1'b0, xq_next} : {1'b0, xq_next};
          y <= y[17] ? -{1'b0, yq_next} : {1'b0, yq_next};
        end
      end
      default: ;
    endcase
  end

  assign out_x = x;
  assign out_y = y;
endmodule

### sv/gsc_merge.sv
`timescale 1ns / 1ps
module gsc_merge (
  input  logic               invert_pitch,
  input  logic signed [17:0] lx,
  input  logic signed [17:0] ly,
  input  logic signed [17:0] rx,
  input  logic signed [17:0] ry,
  output logic signed [15:0] strafe,
  output logic signed [15:0] forward,
  output logic signed [15:0] yaw,
  output logic signed [15:0] pitch
);
  import gsc_pkg::*;

  function automatic logic signed [15:0] sat(input logic signed [17:0] v);
    if (v > 18'sd32767) return 16'sd32767;
    if (v < -18'sd32768) return -16'sd32768;
    return v[15:0];
  endfunction

  always_comb begin
    strafe = sat(lx);
    forward = sat(-ly);
    yaw = sat(rx);
    pitch = sat(invert_pitch ? -ry : ry);
  end
endmodule

### sv/gamepad_stick_conditioner.sv
`timescale 1ns / 1ps
// gamepad stick conditioner
// in channel: in_valid/in_ready with one gamepad frame per item; out channel:
// out_valid/out_ready with the conditioned frame. cfg channel writes dead_zone
// (0), invert_pitch (1) or trigger_threshold (2); other indexes are dropped.
// two stick lanes run side by side, each with a serial square root (24 steps),
// a serial scale divider (23 steps, skipped when the scale clamps to one) and
// two serial axis dividers working together (17 steps).
// an active item's result is valid once both lanes finish, sooner when both
// sticks sit in the dead zone; an inactive item's result the cycle after.
// one item is in flight at a time and the next is accepted once the result
// has been taken.
// the result is held in an output register until taken; while the receiver
// stalls no new item is accepted.
// reset restores register defaults and clears the previous button levels.
module gamepad_stick_conditioner #(
  parameter int BUTTON_COUNT = gsc_pkg::BUTTON_COUNT_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [gsc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [14:0]                         cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                active,
  input  logic signed [15:0]                  left_x,
  input  logic signed [15:0]                  left_y,
  input  logic signed [15:0]                  right_x,
  input  logic signed [15:0]                  right_y,
  input  logic signed [15:0]                  left_trigger,
  input  logic signed [15:0]                  right_trigger,
  input  logic [14:0]                         button_levels,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [15:0]                  strafe,
  output logic signed [15:0]                  forward,
  output logic signed [15:0]                  yaw,
  output logic signed [15:0]                  pitch,
  output logic [14:0]                         held,
  output logic [14:0]                         pressed,
  output logic                                left_trigger_on,
  output logic                                right_trigger_on
);
  import gsc_pkg::*;

  localparam logic [14:0] MASK = 15'((33'd1 << BUTTON_COUNT) - 33'd1);

  logic [14:0] dead_zone, trigger_threshold, previous_buttons;
  logic invert_pitch, busy;
  lane_ctrl_t ctrl;
  logic ldone, rdone, lfin, rfin;
  logic signed [17:0] lx, ly, rx, ry;
  logic signed [15:0] s_n, f_n, y_n, p_n;

  assign cfg_ready = 1'b1;
  assign in_ready = !busy && !out_valid;
  assign ctrl.start = in_valid && in_ready && active;
  assign ctrl.dead_zone = dead_zone;

  gsc_lane u_left (.clk, .rst, .ctrl, .raw_x(left_x), .raw_y(left_y),
    .done(ldone), .out_x(lx), .out_y(ly));
  gsc_lane u_right (.clk, .rst, .ctrl, .raw_x(right_x), .raw_y(right_y),
    .done(rdone), .out_x(rx), .out_y(ry));
  gsc_merge u_merge (.invert_pitch, .lx, .ly, .rx, .ry,
    .strafe(s_n), .forward(f_n), .yaw(y_n), .pitch(p_n));

  always_ff @(posedge clk) begin
    if (rst) begin
      dead_zone <= DEAD_ZONE_RESET;
      invert_pitch <= 1'b0;
      trigger_threshold <= TRIGGER_THRESHOLD_RESET;
      previous_buttons <= '0;
      busy <= 1'b0;
      out_valid <= 1'b0;
      lfin <= 1'b0;
      rfin <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_DEAD_ZONE: dead_zone <= cfg_data;
          REG_INVERT_PITCH: invert_pitch <= cfg_data[0];
          REG_TRIGGER_THRESHOLD: trigger_threshold <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (in_valid && in_ready) begin
        if (active) begin
          busy <= 1'b1;
          lfin <= 1'b0;
          rfin <= 1'b0;
          held <= button_levels & MASK;
          pressed <= button_levels & ~previous_buttons & MASK;
          previous_buttons <= button_levels & MASK;
          left_trigger_on <= (left_trigger[15] ? 15'd0 : left_trigger[14:0]) >=
            trigger_threshold;
          right_trigger_on <= (right_trigger[15] ? 15'd0 : right_trigger[14:0]) >=
            trigger_threshold;
        end else begin
          out_valid <= 1'b1;
          previous_buttons <= '0;
          held <= '0;
          pressed <= '0;
          left_trigger_on <= 1'b0;
          right_trigger_on <= 1'b0;
          strafe <= '0;
          forward <= '0;
          yaw <= '0;
          pitch <= '0;
        end
      end
      if (busy) begin
        if (ldone) lfin <= 1'b1;
        if (rdone) rfin <= 1'b1;
        if ((lfin || ldone) && (rfin || rdone)) begin
          busy <= 1'b0;
          out_valid <= 1'b1;
          strafe <= s_n;
          forward <= f_n;
          yaw <= y_n;
          pitch <= p_n;
        end
      end
    end
  end
endmodule
